// ===== src/ech_pkg.sv =====
// Shared types and constants of the edge coverage hash counter.
`default_nettype none
package ech_pkg;

  localparam int unsigned MapBits = 16;
  localparam int unsigned MapDepth = 1 << MapBits;
  localparam int unsigned PrevBits = MapBits - 1;
  localparam int unsigned IndexBits = 16;
  localparam int unsigned CountBits = 8;
  localparam int unsigned LineBits = 31;

  localparam logic [31:0] HashBasis = 32'h811C_9DC5;
  localparam logic [31:0] HashPrime = 32'h0100_0193;

  localparam int unsigned InDataBits = 56;
  localparam int unsigned OutDataBits = 24;

  typedef enum logic [1:0] {
    KindName = 2'd0,
    KindLine = 2'd1,
    KindRead = 2'd2
  } kind_e;

  localparam logic AnsUpdate = 1'b0;
  localparam logic AnsRead   = 1'b1;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StFold,
    StLookup,
    StRespond
  } state_e;

  typedef struct packed {
    logic clear_wr;
    logic fold_name;
    logic load_line;
    logic fold_line;
    logic finish_line;
    logic load_read;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic line_zero;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== src/ech_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module ech_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/ech_ctrl.sv =====
// Controller state machine of the edge coverage hash counter.
`default_nettype none
module ech_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [1:0]     in_kind_i,
  output logic                in_ready_o,
  input  wire ech_pkg::status_t status_i,
  output ech_pkg::cmd_t       cmd_o
);

  ech_pkg::state_e state_q, state_d;
  logic accept;

  assign in_ready_o = (state_q == ech_pkg::StIdle);
  assign accept = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ech_pkg::StClear;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ech_pkg::StClear: begin
        if (status_i.clear_done) state_d = ech_pkg::StIdle;
      end
      ech_pkg::StIdle: begin
        if (accept) begin
          unique case (ech_pkg::kind_e'(in_kind_i))
            ech_pkg::KindLine: state_d = ech_pkg::StFold;
            ech_pkg::KindRead: state_d = ech_pkg::StLookup;
            default:           state_d = ech_pkg::StIdle;
          endcase
        end
      end
      ech_pkg::StFold: begin
        if (status_i.line_zero) state_d = ech_pkg::StLookup;
      end
      ech_pkg::StLookup: state_d = ech_pkg::StRespond;
      ech_pkg::StRespond: begin
        if (status_i.out_free) state_d = ech_pkg::StIdle;
      end
      default: state_d = ech_pkg::StClear;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ech_pkg::StClear: cmd_o.clear_wr = 1'b1;
      ech_pkg::StIdle: begin
        if (accept) begin
          unique case (ech_pkg::kind_e'(in_kind_i))
            ech_pkg::KindName: cmd_o.fold_name = 1'b1;
            ech_pkg::KindLine: cmd_o.load_line = 1'b1;
            ech_pkg::KindRead: cmd_o.load_read = 1'b1;
            default:           cmd_o = '0;
          endcase
        end
      end
      ech_pkg::StFold: begin
        cmd_o.fold_line   = ~status_i.line_zero;
        cmd_o.finish_line = status_i.line_zero;
      end
      ech_pkg::StLookup: cmd_o = '0;
      ech_pkg::StRespond: cmd_o.respond = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/ech_dp.sv =====
// Datapath: hash register, edge register, counter store and output register.
`default_nettype none
module ech_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire ech_pkg::cmd_t                    cmd_i,
  output ech_pkg::status_t                      status_o,
  input  wire logic [7:0]                       name_byte_i,
  input  wire logic [ech_pkg::LineBits-1:0]     line_number_i,
  input  wire logic [15:0]                      read_address_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic                                  answer_kind_o,
  output logic [ech_pkg::IndexBits-1:0]         edge_index_o,
  output logic [ech_pkg::CountBits-1:0]         hit_count_o
);

  logic [31:0]                    hash_q, hash_d;
  logic [ech_pkg::PrevBits-1:0]   prev_q, prev_d;
  logic [ech_pkg::LineBits-1:0]   line_q, line_d;
  logic [ech_pkg::MapBits-1:0]    idx_q, idx_d;
  logic [ech_pkg::MapBits-1:0]    clr_q;
  logic                           is_read_q, is_read_d;
  logic                           out_valid_q;
  logic                           answer_kind_q;
  logic [ech_pkg::IndexBits-1:0]  edge_index_q;
  logic [ech_pkg::CountBits-1:0]  hit_count_q;

  logic [7:0]                     fold_in;
  logic [31:0]                    hash_prod;
  logic [ech_pkg::MapBits-1:0]    loc;
  logic [ech_pkg::CountBits-1:0]  rdata;
  logic [ech_pkg::CountBits-1:0]  count_new;
  logic                           ram_we;
  logic [ech_pkg::MapBits-1:0]    ram_waddr;
  logic [ech_pkg::CountBits-1:0]  ram_wdata;

  // One FNV-1a step: xor the byte in, multiply by the prime modulo 2^32.
  assign fold_in   = cmd_i.fold_name ? name_byte_i : line_q[7:0];
  assign hash_prod = (hash_q ^ {24'd0, fold_in}) * ech_pkg::HashPrime;
  assign loc       = hash_q[ech_pkg::MapBits-1:0];

  always_comb begin
    hash_d    = hash_q;
    prev_d    = prev_q;
    line_d    = line_q;
    idx_d     = idx_q;
    is_read_d = is_read_q;
    if (cmd_i.fold_name || cmd_i.fold_line) begin
      hash_d = hash_prod;
    end
    if (cmd_i.fold_line) begin
      line_d = line_q >> 8;
    end
    if (cmd_i.load_line) begin
      line_d    = line_number_i;
      is_read_d = 1'b0;
    end
    if (cmd_i.finish_line) begin
      idx_d  = loc ^ {1'b0, prev_q};
      prev_d = loc[ech_pkg::MapBits-1:1];
      hash_d = ech_pkg::HashBasis;
    end
    if (cmd_i.load_read) begin
      idx_d     = ech_pkg::MapBits'(read_address_i);
      is_read_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= ech_pkg::HashBasis;
      prev_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hash_q <= hash_d;
      prev_q <= prev_d;
      if (cmd_i.clear_wr) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.respond) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    line_q    <= line_d;
    idx_q     <= idx_d;
    is_read_q <= is_read_d;
    if (cmd_i.respond) begin
      answer_kind_q <= is_read_q ? ech_pkg::AnsRead : ech_pkg::AnsUpdate;
      edge_index_q  <= ech_pkg::IndexBits'(idx_q);
      hit_count_q   <= count_new;
    end
  end

  assign count_new = is_read_q ? rdata : rdata + 1'b1;

  assign ram_we    = cmd_i.clear_wr | (cmd_i.respond & ~is_read_q);
  assign ram_waddr = cmd_i.clear_wr ? clr_q : idx_q;
  assign ram_wdata = cmd_i.clear_wr ? '0 : count_new;

  ech_ram #(
    .Width (ech_pkg::CountBits),
    .Depth (ech_pkg::MapDepth)
  ) u_counters (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign status_o.clear_done = &clr_q;
  assign status_o.line_zero  = (line_q == '0);
  assign status_o.out_free   = ~out_valid_q | out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign answer_kind_o = answer_kind_q;
  assign edge_index_o  = edge_index_q;
  assign hit_count_o   = hit_count_q;

endmodule
`default_nettype wire

// ===== src/edge_coverage_hash_counter_core.sv =====
// Top level of the edge coverage hash counter.
//
// Input channel s_axis: tuser carries the item kind (name byte, line event,
// counter read); tdata carries name byte, line number and read address.
// Output channel m_axis: tuser carries the answer kind (trace update or read
// answer); tdata carries the edge index and the hit count.
// A name byte folds into the FNV-1a hash in the cycle it is accepted and
// gives no item out; the next item may follow in the very next cycle.
// A line event folds its line bytes one per cycle (0 to 4 bytes, up to the
// highest nonzero one), then forms the edge index, reads the counter store
// and writes back the incremented count while loading the output register.
// A counter read takes its address as the edge index, reads the counter
// store and loads the output register without writing back. The counter
// store has a single registered read port, and name bytes and line bytes
// share one multiplier.
// After reset the counter store is cleared by a pass over all 65536 entries,
// one entry per cycle; s_axis_tready_o stays low until it ends.
// The output register holds a result until it is taken; while it is full and
// not drained, the block holds its next result and accepts no further item until it is loaded.
`default_nettype none
module edge_coverage_hash_counter_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [7:0] name_byte, [38:8] line_number, [54:39] read_address, [55] zero
  input  wire logic [55:0] s_axis_tdata_i,
  // [1:0] kind
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [15:0] edge_index, [23:16] hit_count
  output logic [23:0]      m_axis_tdata_o,
  // [0] answer_kind
  output logic             m_axis_tuser_o
);

  ech_pkg::cmd_t    cmd;
  ech_pkg::status_t status;
  logic [ech_pkg::IndexBits-1:0] edge_index;
  logic [ech_pkg::CountBits-1:0] hit_count;

  // Sequence each item through the fold, index, lookup and write-back steps that its kind needs.
  ech_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_kind_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ech_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .name_byte_i    (s_axis_tdata_i[7:0]),
    .line_number_i  (s_axis_tdata_i[38:8]),
    .read_address_i (s_axis_tdata_i[54:39]),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .answer_kind_o  (m_axis_tuser_o),
    .edge_index_o   (edge_index),
    .hit_count_o    (hit_count)
  );

  assign m_axis_tdata_o = {hit_count, edge_index};

endmodule
`default_nettype wire
